>>> rtl/core/dud_pkg.sv
// Package for the days-until-date core: widths, codes, tables and the divide helper.
package dud_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 22;
    localparam int STATUS_W = 2;
    localparam int DNUM_W   = 23;
    localparam int MDAY_W   = 9;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PAST    = 2'd2;

    localparam logic [1:0] REG_TODAY_YEAR  = 2'd0;
    localparam logic [1:0] REG_TODAY_MONTH = 2'd1;
    localparam logic [1:0] REG_TODAY_DAY   = 2'd2;

    localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2000;
    localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // x/25 = (x * 10486) >> 18, exact for x below 8192
    localparam logic [13:0] DIV25_MUL = 14'd10486;

    localparam logic [DAY_W-1:0] COMMON_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };
    localparam logic [DAY_W-1:0] LEAP_LEN [16] = '{
        5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };
    // days before the first of each month in a common year
    localparam logic [MDAY_W-1:0] CUM_DAYS [16] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_ref_date;

    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
    } t_pipe_ctl;

    function automatic logic [8:0] div25(input logic [12:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'(DIV25_MUL);
        return p[26:18];
    endfunction

endpackage

>>> rtl/core/dud_if.sv
// Valid/ready stream interfaces for target dates and day-count results.
interface dud_in_if;
    logic                         valid;
    logic                         ready;
    logic [dud_pkg::YEAR_W-1:0]   target_year;
    logic [dud_pkg::MONTH_W-1:0]  target_month;
    logic [dud_pkg::DAY_W-1:0]    target_day;

    modport source(output valid, target_year, target_month, target_day, input ready);
    modport sink(input valid, target_year, target_month, target_day, output ready);
endinterface

interface dud_out_if;
    logic                          valid;
    logic                          ready;
    logic [dud_pkg::COUNT_W-1:0]   day_count;
    logic [dud_pkg::STATUS_W-1:0]  status;

    modport source(output valid, day_count, status, input ready);
    modport sink(input valid, day_count, status, output ready);
endinterface

>>> rtl/core/dud_apb_regs.sv
// APB register block holding the reference date.
module dud_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dud_pkg::ADDR_W-1:0]  paddr,
    input  logic [dud_pkg::DATA_W-1:0]  pwdata,
    output logic [dud_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output dud_pkg::t_ref_date          o_ref
);

    dud_pkg::t_ref_date r_ref;
    logic               wr_en;
    logic [1:0]         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign o_ref  = r_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref.year  <= dud_pkg::RST_YEAR;
            r_ref.month <= dud_pkg::RST_MONTH;
            r_ref.day   <= dud_pkg::RST_DAY;
        end else if (wr_en) begin
            unique case (idx)
                dud_pkg::REG_TODAY_YEAR:  r_ref.year  <= pwdata[dud_pkg::YEAR_W-1:0];
                dud_pkg::REG_TODAY_MONTH: r_ref.month <= pwdata[dud_pkg::MONTH_W-1:0];
                dud_pkg::REG_TODAY_DAY:   r_ref.day   <= pwdata[dud_pkg::DAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            dud_pkg::REG_TODAY_YEAR:  prdata = dud_pkg::DATA_W'(r_ref.year);
            dud_pkg::REG_TODAY_MONTH: prdata = dud_pkg::DATA_W'(r_ref.month);
            dud_pkg::REG_TODAY_DAY:   prdata = dud_pkg::DATA_W'(r_ref.day);
            default:                  prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/dud_daynum.sv
// Three-stage pipeline turning a date into a day number from year 0, with a validity flag.
module dud_daynum (
    input  logic                         i_clk,
    input  dud_pkg::t_pipe_ctl           i_ctl,
    input  logic [dud_pkg::YEAR_W-1:0]   i_year,
    input  logic [dud_pkg::MONTH_W-1:0]  i_month,
    input  logic [dud_pkg::DAY_W-1:0]    i_day,
    output logic [dud_pkg::DNUM_W-1:0]   o_day_num,
    output logic                         o_date_ok
);

    // stage 1: inputs and the three quotients by 100 / 400
    logic [dud_pkg::YEAR_W-1:0]  r1_year;
    logic [dud_pkg::MONTH_W-1:0] r1_month;
    logic [dud_pkg::DAY_W-1:0]   r1_day;
    logic [7:0]                  r1_qa;   // (y+99)/100
    logic [5:0]                  r1_qb;   // (y+399)/400
    logic [7:0]                  r1_qc;   // y/100
    logic [14:0]                 y_p99;
    logic [14:0]                 y_p399;
    logic [8:0]                  qa_full;
    logic [8:0]                  qb_full;
    logic [8:0]                  qc_full;

    // stage 2: year base and day within year
    logic [dud_pkg::DNUM_W-1:0]  r2_base;
    logic [dud_pkg::MDAY_W-1:0]  r2_mday;
    logic                        r2_ok;
    logic [11:0]                 qc_x25;
    logic [11:0]                 rem100;
    logic                        leap;
    logic [14:0]                 y_p3;
    logic [12:0]                 leaps;
    logic [dud_pkg::DAY_W-1:0]   mlen;
    logic                        mon_ok;
    logic [dud_pkg::DNUM_W-1:0]  n2_base;
    logic [dud_pkg::MDAY_W-1:0]  n2_mday;
    logic                        n2_ok;

    // stage 3: day number
    logic [dud_pkg::DNUM_W-1:0]  r3_dn;
    logic                        r3_ok;

    always_comb begin
        y_p99   = {1'b0, i_year} + 15'd99;
        y_p399  = {1'b0, i_year} + 15'd399;
        qa_full = dud_pkg::div25(y_p99[14:2]);
        qb_full = dud_pkg::div25({2'b00, y_p399[14:4]});
        qc_full = dud_pkg::div25({1'b0, i_year[13:2]});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r1_year  <= i_year;
            r1_month <= i_month;
            r1_day   <= i_day;
            r1_qa    <= qa_full[7:0];
            r1_qb    <= qb_full[5:0];
            r1_qc    <= qc_full[7:0];
        end
    end

    always_comb begin
        qc_x25  = {4'b0000, r1_qc} * 12'd25;
        rem100  = r1_year[13:2] - qc_x25;
        // divisible by 4, and either not by 100 or also by 400
        leap    = (r1_year[1:0] == 2'b00) && ((rem100 != 12'd0) || (r1_qc[1:0] == 2'b00));
        y_p3    = {1'b0, r1_year} + 15'd3;
        leaps   = y_p3[14:2] - {5'b00000, r1_qa} + {7'b0000000, r1_qb};
        n2_base = dud_pkg::DNUM_W'(r1_year) * 23'd365 + dud_pkg::DNUM_W'(leaps);
        n2_mday = dud_pkg::CUM_DAYS[r1_month]
                + dud_pkg::MDAY_W'(leap && (r1_month > 4'd2))
                + dud_pkg::MDAY_W'(r1_day);
        mlen    = leap ? dud_pkg::LEAP_LEN[r1_month] : dud_pkg::COMMON_LEN[r1_month];
        mon_ok  = (r1_month >= 4'd1) && (r1_month <= 4'd12);
        n2_ok   = mon_ok && (r1_day != 5'd0) && (r1_day <= mlen);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv2) begin
            r2_base <= n2_base;
            r2_mday <= n2_mday;
            r2_ok   <= n2_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv3) begin
            r3_dn <= r2_base + dud_pkg::DNUM_W'(r2_mday);
            r3_ok <= r2_ok;
        end
    end

    assign o_day_num = r3_dn;
    assign o_date_ok = r3_ok;

endmodule

>>> rtl/core/dud_result.sv
// Output stage: compare the two day numbers and register count and status.
module dud_result (
    input  logic                          i_clk,
    input  logic                          i_adv,
    input  logic [dud_pkg::DNUM_W-1:0]    i_tgt_num,
    input  logic                          i_tgt_ok,
    input  logic [dud_pkg::DNUM_W-1:0]    i_ref_num,
    input  logic                          i_ref_ok,
    output logic [dud_pkg::COUNT_W-1:0]   o_day_count,
    output logic [dud_pkg::STATUS_W-1:0]  o_status
);

    logic [dud_pkg::COUNT_W-1:0]  r_count;
    logic [dud_pkg::STATUS_W-1:0] r_status;
    logic [dud_pkg::DNUM_W-1:0]   diff;
    logic [dud_pkg::COUNT_W-1:0]  n_count;
    logic [dud_pkg::STATUS_W-1:0] n_status;

    always_comb begin
        diff = i_tgt_num - i_ref_num;
        priority if (!(i_tgt_ok && i_ref_ok)) begin
            n_status = dud_pkg::ST_INVALID;
            n_count  = '0;
        end else if (i_tgt_num < i_ref_num) begin
            n_status = dud_pkg::ST_PAST;
            n_count  = '0;
        end else begin
            n_status = dud_pkg::ST_OK;
            n_count  = diff[dud_pkg::DNUM_W-1] ? dud_pkg::COUNT_MAX
                                               : diff[dud_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    assign o_day_count = r_count;
    assign o_status    = r_status;

endmodule

>>> rtl/core/days_until_date_core.sv
// Top level of the days-until-date core: APB registers, two date pipelines, result stage.
//
// Usage:
//   Program the reference date (today_year at 0x0, today_month at 0x4, today_day at 0x8)
//   over the APB port while no word is in flight. Then stream target dates on i_target;
//   each accepted word yields exactly one word on o_result carrying day_count and status
//   (ok, invalid date, or target earlier than reference; count is zero unless ok).
//   Counts above the 22-bit range saturate at the all-ones value.
// Stages: three date stages and one result stage. Throughput: one word per cycle while
//   o_result.ready is high; every stage has its own valid bit and advances when it is
//   empty or its successor advances, so bubbles collapse under a stall.
// Reset: synchronous active-low i_rst_n empties the pipeline and restores the reference
//   date to 2000-01-01.
// Stall: when o_result.ready is low the held result stays put and stable; upstream stages
//   keep filling until the pipeline is full, then i_target.ready drops. Nothing is lost
//   or repeated.
// The reference date runs through its own copy of the date pipeline, in lockstep with
//   each target word.
module days_until_date_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dud_pkg::ADDR_W-1:0]  paddr,
    input  logic [dud_pkg::DATA_W-1:0]  pwdata,
    output logic [dud_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    dud_in_if.sink                      i_target,
    dud_out_if.source                   o_result
);

    dud_pkg::t_ref_date          ref_date;
    dud_pkg::t_pipe_ctl          ctl;
    logic [3:0]                  r_vld;
    logic [3:0]                  adv;
    logic [dud_pkg::DNUM_W-1:0]  tgt_num;
    logic [dud_pkg::DNUM_W-1:0]  ref_num;
    logic                        tgt_ok;
    logic                        ref_ok;

    dud_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ref   (ref_date)
    );

    // stage k advances when empty or when the stage after it advances
    assign adv[3] = !r_vld[3] || o_result.ready;
    assign adv[2] = !r_vld[2] || adv[3];
    assign adv[1] = !r_vld[1] || adv[2];
    assign adv[0] = !r_vld[0] || adv[1];

    assign i_target.ready = adv[0];
    assign o_result.valid = r_vld[3];

    assign ctl.adv1 = adv[0];
    assign ctl.adv2 = adv[1];
    assign ctl.adv3 = adv[2];

    // advance valid bits alongside the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_target.valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    dud_daynum u_tgt_num (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_year    (i_target.target_year),
        .i_month   (i_target.target_month),
        .i_day     (i_target.target_day),
        .o_day_num (tgt_num),
        .o_date_ok (tgt_ok)
    );

    dud_daynum u_ref_num (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_year    (ref_date.year),
        .i_month   (ref_date.month),
        .i_day     (ref_date.day),
        .o_day_num (ref_num),
        .o_date_ok (ref_ok)
    );

    dud_result u_result (
        .i_clk       (i_clk),
        .i_adv       (adv[3]),
        .i_tgt_num   (tgt_num),
        .i_tgt_ok    (tgt_ok),
        .i_ref_num   (ref_num),
        .i_ref_ok    (ref_ok),
        .o_day_count (o_result.day_count),
        .o_status    (o_result.status)
    );

endmodule

>>> rtl/core/dud_checker.sv
// Port-level checker for the days-until-date core, with its bind.
module dud_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [dud_pkg::COUNT_W-1:0]   i_day_count,
    input  logic [dud_pkg::STATUS_W-1:0]  i_status
);

    // hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_day_count)
                                        && $stable(i_status))
        else $error("stalled result word changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == dud_pkg::ST_OK) || (i_status == dud_pkg::ST_INVALID)
                        || (i_status == dud_pkg::ST_PAST))
        else $error("unknown status code");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != dud_pkg::ST_OK) |-> i_day_count == '0)
        else $error("nonzero count with error status");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word right after reset");

endmodule

bind days_until_date_core dud_checker u_dud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_day_count (o_result.day_count),
    .i_status    (o_result.status)
);
